[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  `ASSERT_PROP(label, clk, rst_n, !(expr))
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[hw/rtl/pcab_pkg.sv]
// ----------------------------------------------------------------------------
// PCI config access bridge package
// Codes, command and result beat types and lane helpers.
// ----------------------------------------------------------------------------
package pcab_pkg;

  localparam logic [1:0] SZ_BYTE  = 2'd0;
  localparam logic [1:0] SZ_WORD  = 2'd1;
  localparam logic [1:0] SZ_DWORD = 2'd2;
  localparam logic [1:0] SZ_BAD   = 2'd3;

  localparam logic [0:0] CFG_HOST_BUS  = 1'd0;
  localparam logic [0:0] CFG_SLOT_MASK = 1'd1;

  typedef enum logic [1:0] {
    KIND_REPLY     = 2'd0,
    KIND_DEV_READ  = 2'd1,
    KIND_DEV_WRITE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_READ = 2'd1,
    PEND_RMW  = 2'd2
  } pend_t;

  typedef enum logic [2:0] {
    OP_REPLY     = 3'd0,
    OP_DEV_READ  = 3'd1,
    OP_DEV_WRITE = 3'd2,
    OP_RMW       = 3'd3,
    OP_RESP      = 3'd4
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  lane;
    logic [1:0]  size;
    logic [31:0] addr;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] reply_data;
    logic [31:0] target_address;
    logic [1:0]  access_size;
    logic [31:0] write_value;
  } res_t;

  function automatic logic [31:0] size_mask(input logic [1:0] size);
    logic [31:0] m;
    case (size)
      SZ_BYTE: m = 32'h0000_00ff;
      SZ_WORD: m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] lane_shl(input logic [31:0] d, input logic [1:0] lane);
    logic [31:0] r;
    case (lane)
      2'd0:    r = d;
      2'd1:    r = {d[23:0], 8'h00};
      2'd2:    r = {d[15:0], 16'h0000};
      default: r = {d[7:0], 24'h000000};
    endcase
    return r;
  endfunction

  function automatic logic [31:0] lane_shr(input logic [31:0] d, input logic [1:0] lane);
    logic [31:0] r;
    case (lane)
      2'd0:    r = d;
      2'd1:    r = {8'h00, d[31:8]};
      2'd2:    r = {16'h0000, d[31:16]};
      default: r = {24'h000000, d[31:24]};
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/pcab_fifo.sv]
// ----------------------------------------------------------------------------
// PCI config access bridge queue
// Small first-word-fall-through queue; push and pop may share a cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcab_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2   // 2..16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_PROP(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH))
  `ASSERT_NEVER(a_push_when_full, clk, rst_n, push && full)
  `ASSERT_PROP(a_fill_one, clk, rst_n, (do_push && !do_pop && empty) |=> (count_r == CW'(1)))

endmodule

[hw/rtl/pcab_front.sv]
// ----------------------------------------------------------------------------
// PCI config access bridge front end
// Holds config and the address register, classifies each port access.
// ----------------------------------------------------------------------------
module pcab_front #(
  parameter int SLOT_COUNT = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               accept,
  input  logic               func,
  input  logic [2:0]         port_offset,
  input  logic [1:0]         size_code,
  input  logic               is_write,
  input  logic [31:0]        write_data,
  input  logic [31:0]        response_data,
  output logic               cmd_push,
  output pcab_pkg::cmd_t     cmd
);

  logic [7:0]  host_bus_r;
  logic [31:0] slot_mask_r;
  logic [31:0] addr_r, addr_nxt;
  logic [1:0]  lane;
  logic [31:0] m;
  logic        legal;
  logic        present;
  logic [4:0]  slot;
  logic        want_cmd;

  assign lane = port_offset[1:0];
  assign m    = pcab_pkg::size_mask(size_code);
  assign slot = addr_r[15:11];

  always_comb begin
    case (size_code)
      pcab_pkg::SZ_BYTE:  legal = 1'b1;
      pcab_pkg::SZ_WORD:  legal = (lane != 2'd3);
      pcab_pkg::SZ_DWORD: legal = (lane == 2'd0);
      default:            legal = 1'b0;
    endcase
  end

  assign present = (addr_r[23:16] == host_bus_r) &&
                   ({1'b0, slot} < 6'(SLOT_COUNT)) && slot_mask_r[slot];

  always_comb begin
    want_cmd  = 1'b0;
    addr_nxt  = addr_r;
    cmd.op    = pcab_pkg::OP_REPLY;
    cmd.lane  = lane;
    cmd.size  = size_code;
    cmd.addr  = addr_r;
    cmd.data  = '0;
    if (func) begin
      want_cmd = 1'b1;
      cmd.op   = pcab_pkg::OP_RESP;
      cmd.data = response_data;
    end else if (!legal) begin
      want_cmd = !is_write;
      cmd.data = 32'hffff_ffff;
    end else if (!port_offset[2]) begin
      if (is_write) begin
        addr_nxt = (addr_r & ~pcab_pkg::lane_shl(m, lane)) |
                   pcab_pkg::lane_shl(write_data & m, lane);
      end else begin
        want_cmd = 1'b1;
        cmd.data = pcab_pkg::lane_shr(addr_r, lane) & m;
      end
    end else if (!present) begin
      want_cmd = !is_write;
      cmd.data = m;
    end else if (!is_write) begin
      want_cmd = 1'b1;
      cmd.op   = pcab_pkg::OP_DEV_READ;
    end else if (lane == 2'd0) begin
      want_cmd = 1'b1;
      cmd.op   = pcab_pkg::OP_DEV_WRITE;
      cmd.data = write_data & m;
    end else begin
      want_cmd = 1'b1;
      cmd.op   = pcab_pkg::OP_RMW;
      cmd.data = write_data & m & 32'h0000_ffff;
    end
  end

  assign cmd_push = accept && want_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_bus_r  <= '0;
      slot_mask_r <= '0;
      addr_r      <= '0;
    end else begin
      if (cfg_wr_en && cfg_index == pcab_pkg::CFG_HOST_BUS) begin
        host_bus_r <= cfg_wdata[7:0];
      end
      if (cfg_wr_en && cfg_index == pcab_pkg::CFG_SLOT_MASK) begin
        slot_mask_r <= cfg_wdata;
      end
      if (accept) begin
        addr_r <= addr_nxt;
      end
    end
  end

endmodule

[hw/rtl/pcab_back.sv]
// ----------------------------------------------------------------------------
// PCI config access bridge back end
// Tracks the pending device read and forms result beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcab_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  pcab_pkg::cmd_t     cmd,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_push,
  output pcab_pkg::res_t     res
);

  pcab_pkg::pend_t pend_kind_r, pend_kind_nxt;
  logic [1:0]      pend_lane_r, pend_lane_nxt;
  logic [1:0]      pend_size_r, pend_size_nxt;
  logic [15:0]     pend_wdata_r, pend_wdata_nxt;
  logic            has_res;
  logic [31:0]     lane_m;

  assign lane_m = pcab_pkg::lane_shl(pcab_pkg::size_mask(pend_size_r), pend_lane_r);

  always_comb begin
    has_res        = 1'b0;
    res            = '0;
    pend_kind_nxt  = pend_kind_r;
    pend_lane_nxt  = pend_lane_r;
    pend_size_nxt  = pend_size_r;
    pend_wdata_nxt = pend_wdata_r;
    case (cmd.op)
      pcab_pkg::OP_REPLY: begin
        has_res        = 1'b1;
        res.kind       = pcab_pkg::KIND_REPLY;
        res.reply_data = cmd.data;
      end
      pcab_pkg::OP_DEV_READ: begin
        has_res            = 1'b1;
        res.kind           = pcab_pkg::KIND_DEV_READ;
        res.target_address = cmd.addr;
        res.access_size    = pcab_pkg::SZ_DWORD;
        pend_kind_nxt      = pcab_pkg::PEND_READ;
        pend_lane_nxt      = cmd.lane;
        pend_size_nxt      = cmd.size;
      end
      pcab_pkg::OP_DEV_WRITE: begin
        has_res            = 1'b1;
        res.kind           = pcab_pkg::KIND_DEV_WRITE;
        res.target_address = cmd.addr;
        res.access_size    = cmd.size;
        res.write_value    = cmd.data;
      end
      pcab_pkg::OP_RMW: begin
        has_res            = 1'b1;
        res.kind           = pcab_pkg::KIND_DEV_READ;
        res.target_address = cmd.addr;
        res.access_size    = pcab_pkg::SZ_DWORD;
        pend_kind_nxt      = pcab_pkg::PEND_RMW;
        pend_lane_nxt      = cmd.lane;
        pend_size_nxt      = cmd.size;
        pend_wdata_nxt     = cmd.data[15:0];
      end
      pcab_pkg::OP_RESP: begin
        pend_kind_nxt = pcab_pkg::PEND_NONE;
        case (pend_kind_r)
          pcab_pkg::PEND_READ: begin
            has_res        = 1'b1;
            res.kind       = pcab_pkg::KIND_REPLY;
            res.reply_data = pcab_pkg::lane_shr(cmd.data, pend_lane_r) &
                             pcab_pkg::size_mask(pend_size_r);
          end
          pcab_pkg::PEND_RMW: begin
            has_res            = 1'b1;
            res.kind           = pcab_pkg::KIND_DEV_WRITE;
            res.target_address = cmd.addr;
            res.access_size    = pcab_pkg::SZ_DWORD;
            res.write_value    = (cmd.data & ~lane_m) |
                                 (pcab_pkg::lane_shl({16'h0000, pend_wdata_r}, pend_lane_r) &
                                  lane_m);
          end
          default: begin
            has_res = 1'b0;
          end
        endcase
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  assign cmd_pop  = cmd_valid && (!has_res || !res_full);
  assign res_push = cmd_valid && has_res && !res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_kind_r  <= pcab_pkg::PEND_NONE;
      pend_lane_r  <= '0;
      pend_size_r  <= '0;
      pend_wdata_r <= '0;
    end else if (cmd_pop) begin
      pend_kind_r  <= pend_kind_nxt;
      pend_lane_r  <= pend_lane_nxt;
      pend_size_r  <= pend_size_nxt;
      pend_wdata_r <= pend_wdata_nxt;
    end
  end

  `ASSERT_PROP(a_resp_clears, clk, rst_n,
    (cmd_pop && cmd.op == pcab_pkg::OP_RESP) |=> (pend_kind_r == pcab_pkg::PEND_NONE))
  `ASSERT_PROP(a_rmw_pends, clk, rst_n,
    (cmd_pop && cmd.op == pcab_pkg::OP_RMW) |=> (pend_kind_r == pcab_pkg::PEND_RMW))
  `ASSERT_PROP(a_push_implies_pop, clk, rst_n, res_push |-> cmd_pop)

endmodule

[hw/rtl/pci_config_access_bridge_unit.sv]
// Path: an accepted access reaches the out_ ports as a result beat by way of the command
// queue and then the result queue, each of them registered, when nothing stalls.
// Throughput: one access per cycle; the back end drains one command per cycle, and
// in_full rises only when the command queue is full behind a stalled result side.
// Reset: synchronous active-low rst_n clears config, the address register, the
// pending device read and both queues; the block takes accesses the cycle after.
// ----------------------------------------------------------------------------
// PCI config access bridge
// Address/data port host bridge: front end decodes CPU port accesses and
// device responses, a command queue decouples it from the back end, which
// tracks the pending device read and forms result beats into a result queue.
// ----------------------------------------------------------------------------
module pci_config_access_bridge_unit #(
  parameter int SLOT_COUNT = 32,  // device slots that may be present, 1..32
  parameter int CMD_DEPTH  = 2,   // command queue entries, 2..16
  parameter int RES_DEPTH  = 2    // result queue entries, 2..16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // input beats
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_func,
  input  logic [2:0]  in_port_offset,
  input  logic [1:0]  in_size_code,
  input  logic        in_is_write,
  input  logic [31:0] in_write_data,
  input  logic [31:0] in_response_data,
  // result beats
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [31:0] out_reply_data,
  output logic [31:0] out_target_address,
  output logic [1:0]  out_access_size,
  output logic [31:0] out_write_value
);

  localparam int CMD_W = $bits(pcab_pkg::cmd_t);
  localparam int RES_W = $bits(pcab_pkg::res_t);

  logic            accept;
  logic            cmd_push;
  pcab_pkg::cmd_t  cmd_in;
  pcab_pkg::cmd_t  cmd_head;
  logic            cmd_empty;
  logic            cmd_pop;
  logic            res_full;
  logic            res_push;
  pcab_pkg::res_t  res_in;
  pcab_pkg::res_t  res_head;

  // Accept whenever the command queue has room; accesses that make no
  // command (address writes, dropped writes) still take the beat.
  assign accept = in_push && !in_full;

  pcab_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .accept        (accept),
    .func          (in_func),
    .port_offset   (in_port_offset),
    .size_code     (in_size_code),
    .is_write      (in_is_write),
    .write_data    (in_write_data),
    .response_data (in_response_data),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in)
  );

  // Command queue between decode and execution.
  pcab_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (in_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_head),
    .empty     (cmd_empty)
  );

  pcab_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue: hold finished beats while the consumer stalls.
  pcab_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_head),
    .empty     (out_empty)
  );

  assign out_kind           = res_head.kind;
  assign out_reply_data     = res_head.reply_data;
  assign out_target_address = res_head.target_address;
  assign out_access_size    = res_head.access_size;
  assign out_write_value    = res_head.write_value;

endmodule

[tb/sv/tb_pci_config_access_bridge_unit.sv]
// ----------------------------------------------------------------------------
// PCI config access bridge testbench
// Pushes CPU port accesses and device read responses into the bridge, runs a
// cycle-free model of the address/data port pair next to it, and compares
// every popped result beat against the model's beat, field by field, under
// random idling on both sides and several host bus / slot settings.
// ----------------------------------------------------------------------------
module tb_pci_config_access_bridge_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS = 32;

  // One input beat as queued for the driver; sync holds it back until every
  // expected result beat has been popped.
  typedef struct {
    logic        func;
    logic [2:0]  offset;
    logic [1:0]  size;
    logic        is_wr;
    logic [31:0] wdata;
    logic [31:0] resp;
    bit          sync;
  } access_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_push;
  logic        in_full;
  logic        in_func;
  logic [2:0]  in_port_offset;
  logic [1:0]  in_size_code;
  logic        in_is_write;
  logic [31:0] in_write_data;
  logic [31:0] in_response_data;
  logic        out_empty;
  logic        out_pop;
  logic [1:0]  out_kind;
  logic [31:0] out_reply_data;
  logic [31:0] out_target_address;
  logic [1:0]  out_access_size;
  logic [31:0] out_write_value;

  // Bridge state as the model sees it.
  logic [7:0]      m_bus;
  logic [31:0]     m_slots;
  logic [31:0]     m_addr;
  pcab_pkg::pend_t m_pend;
  logic [1:0]      m_pend_lane;
  logic [1:0]      m_pend_size;
  logic [15:0]     m_pend_wdata;

  access_t        stim_q[$];
  pcab_pkg::res_t due_beats[$];
  access_t        tx_cur;
  bit             tx_fire;
  bit             tx_burst;
  bit             rx_burst;
  int             tx_wait;
  int             rx_wait;
  int             rx_hold;
  int             n_queued;
  int             n_accepted;
  int             n_beats;
  int             n_errors;
  int             n_settings;

  pci_config_access_bridge_unit #(.SLOT_COUNT(NUM_SLOTS)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_func           (in_func),
    .in_port_offset    (in_port_offset),
    .in_size_code      (in_size_code),
    .in_is_write       (in_is_write),
    .in_write_data     (in_write_data),
    .in_response_data  (in_response_data),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_kind          (out_kind),
    .out_reply_data    (out_reply_data),
    .out_target_address(out_target_address),
    .out_access_size   (out_access_size),
    .out_write_value   (out_write_value)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] size_ones(input logic [1:0] sz);
    if (sz == pcab_pkg::SZ_BYTE) return 32'h0000_00ff;
    if (sz == pcab_pkg::SZ_WORD) return 32'h0000_ffff;
    return 32'hffff_ffff;
  endfunction

  // Model one accepted beat: update the bridge state and queue the result
  // beat it causes, if any.
  task automatic bridge_decode(input access_t a);
    pcab_pkg::res_t r;
    logic [1:0]     lane;
    logic [4:0]     sh;
    logic [4:0]     slot;
    logic [31:0]    m;
    logic           ok;
    logic           hit;
    r = '0;
    // Device response: complete whatever is pending, drop it otherwise.
    if (a.func) begin
      sh = {m_pend_lane, 3'b000};
      if (m_pend == pcab_pkg::PEND_READ) begin
        r.kind = pcab_pkg::KIND_REPLY;
        r.reply_data = (a.resp >> sh) & size_ones(m_pend_size);
        due_beats.push_back(r);
      end else if (m_pend == pcab_pkg::PEND_RMW) begin
        // Merge at the remembered lane; write back to the address as it is now.
        m = size_ones(m_pend_size) << sh;
        r.kind = pcab_pkg::KIND_DEV_WRITE;
        r.target_address = m_addr;
        r.access_size = pcab_pkg::SZ_DWORD;
        r.write_value = (a.resp & ~m) | (({16'h0000, m_pend_wdata} << sh) & m);
        due_beats.push_back(r);
      end
      m_pend = pcab_pkg::PEND_NONE;
      return;
    end
    lane = a.offset[1:0];
    case (a.size)
      pcab_pkg::SZ_BYTE:  ok = 1'b1;
      pcab_pkg::SZ_WORD:  ok = (lane <= 2'd2);
      pcab_pkg::SZ_DWORD: ok = (lane == 2'd0);
      default:            ok = 1'b0;
    endcase
    // Bad size or alignment: reads reply all ones, writes vanish.
    if (!ok) begin
      if (!a.is_wr) begin
        r.kind = pcab_pkg::KIND_REPLY;
        r.reply_data = 32'hffff_ffff;
        due_beats.push_back(r);
      end
      return;
    end
    sh = {lane, 3'b000};
    m = size_ones(a.size);
    // Address port: merge or extract lanes locally.
    if (!a.offset[2]) begin
      if (a.is_wr) begin
        m_addr = (m_addr & ~(m << sh)) | ((a.wdata & m) << sh);
      end else begin
        r.kind = pcab_pkg::KIND_REPLY;
        r.reply_data = (m_addr >> sh) & m;
        due_beats.push_back(r);
      end
      return;
    end
    slot = m_addr[15:11];
    hit = (m_addr[23:16] == m_bus) && (int'(slot) < NUM_SLOTS) && m_slots[slot];
    if (!hit) begin
      if (!a.is_wr) begin
        r.kind = pcab_pkg::KIND_REPLY;
        r.reply_data = m;
        due_beats.push_back(r);
      end
      return;
    end
    r.target_address = m_addr;
    if (a.is_wr && lane == 2'd0) begin
      r.kind = pcab_pkg::KIND_DEV_WRITE;
      r.access_size = a.size;
      r.write_value = a.wdata & m;
      due_beats.push_back(r);
      return;
    end
    // Data read or unaligned write: dword device read, remember the lane.
    m_pend = a.is_wr ? pcab_pkg::PEND_RMW : pcab_pkg::PEND_READ;
    m_pend_lane = lane;
    m_pend_size = a.size;
    if (a.is_wr) m_pend_wdata = a.wdata[15:0] & m[15:0];
    r.kind = pcab_pkg::KIND_DEV_READ;
    r.access_size = pcab_pkg::SZ_DWORD;
    due_beats.push_back(r);
  endtask

  // Compare the beat on the out_ ports with the oldest expected beat.
  task automatic check_beat();
    pcab_pkg::res_t want;
    if (due_beats.size() == 0) begin
      $error("unexpected result beat: kind %0d reply %h addr %h", out_kind, out_reply_data,
             out_target_address);
      n_errors++;
      return;
    end
    want = due_beats.pop_front();
    if (out_kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, out_kind);
      n_errors++;
    end
    if (out_reply_data !== want.reply_data) begin
      $error("reply_data: expected %h, got %h", want.reply_data, out_reply_data);
      n_errors++;
    end
    if (out_target_address !== want.target_address) begin
      $error("target_address: expected %h, got %h", want.target_address, out_target_address);
      n_errors++;
    end
    if (out_access_size !== want.access_size) begin
      $error("access_size: expected %0d, got %0d", want.access_size, out_access_size);
      n_errors++;
    end
    if (out_write_value !== want.write_value) begin
      $error("write_value: expected %h, got %h", want.write_value, out_write_value);
      n_errors++;
    end
  endtask

  // Driver: feed beats from the pending queue, hold while full, idle between
  // beats. The model runs on the beat at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      tx_fire = in_push && !in_full;
      if (tx_fire) begin
        bridge_decode(tx_cur);
        n_accepted++;
        if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
        tx_wait = tx_burst ? 0 : $urandom_range(0, 8);
      end
      if (in_push && !tx_fire) begin
        // hold the beat until the bridge takes it
      end else if (tx_wait > 0) begin
        tx_wait--;
        in_push <= 1'b0;
      end else if (stim_q.size() > 0 && !(stim_q[0].sync && due_beats.size() != 0)) begin
        tx_cur = stim_q.pop_front();
        in_func          <= tx_cur.func;
        in_port_offset   <= tx_cur.offset;
        in_size_code     <= tx_cur.size;
        in_is_write      <= tx_cur.is_wr;
        in_write_data    <= tx_cur.wdata;
        in_response_data <= tx_cur.resp;
        in_push          <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Monitor: pop result beats with random stalls, and twice hold off long
  // enough for the bridge to back up into in_full.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        check_beat();
        n_beats++;
        if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 8);
        if (n_beats == 120 || n_beats == 300) rx_hold = 80;
      end else if (rx_hold > 0) begin
        rx_hold--;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_pop <= (rx_wait == 0 && rx_hold == 0);
    end
  end

  function automatic access_t cpu_beat(input logic [2:0] off, input logic [1:0] sz,
                                       input logic wr, input logic [31:0] d);
    access_t a;
    a.func = 1'b0;
    a.offset = off;
    a.size = sz;
    a.is_wr = wr;
    a.wdata = d;
    a.resp = $urandom();
    a.sync = 1'b0;
    return a;
  endfunction

  function automatic access_t resp_beat(input logic [31:0] d);
    access_t a;
    a.func = 1'b1;
    a.offset = 3'($urandom_range(0, 7));
    a.size = 2'($urandom_range(0, 3));
    a.is_wr = 1'($urandom_range(0, 1));
    a.wdata = $urandom();
    a.resp = d;
    a.sync = 1'b0;
    return a;
  endfunction

  // A size that is legal at the given lane.
  function automatic logic [1:0] legal_size(input logic [1:0] lane);
    int r;
    r = $urandom_range(0, 2);
    if (lane == 2'd0 && r == 2) return pcab_pkg::SZ_DWORD;
    if (lane != 2'd3 && r >= 1) return pcab_pkg::SZ_WORD;
    return pcab_pkg::SZ_BYTE;
  endfunction

  task automatic enqueue(input access_t a);
    stim_q.push_back(a);
    n_queued++;
  endtask

  // Write both bridge registers; only called with nothing in flight.
  task automatic set_bridge(input logic [7:0] bus, input logic [31:0] slots);
    logic [31:0] w;
    w = $urandom();
    w[7:0] = bus;
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= pcab_pkg::CFG_HOST_BUS;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= pcab_pkg::CFG_SLOT_MASK;
    cfg_wdata <= slots;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    m_bus = bus;
    m_slots = slots;
    n_settings++;
  endtask

  // Wait for the queue to drain and every result to come back, then let any
  // silent access still in the pipe retire.
  task automatic settle();
    while (!(stim_q.size() == 0 && n_accepted == n_queued && !in_push)) @(posedge clk);
    while (due_beats.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic queue_directed();
    access_t a;
    // address port lanes, both extremes of the data
    enqueue(cpu_beat(3'd0, pcab_pkg::SZ_DWORD, 1'b1, 32'hffff_ffff));
    enqueue(cpu_beat(3'd0, pcab_pkg::SZ_DWORD, 1'b0, 32'h0));
    enqueue(cpu_beat(3'd1, pcab_pkg::SZ_BYTE, 1'b1, 32'h0000_0000));
    enqueue(cpu_beat(3'd2, pcab_pkg::SZ_WORD, 1'b0, 32'h0));
    enqueue(cpu_beat(3'd3, pcab_pkg::SZ_BYTE, 1'b0, 32'h0));
    // misaligned and invalid sizes
    enqueue(cpu_beat(3'd3, pcab_pkg::SZ_WORD, 1'b0, 32'h0));
    enqueue(cpu_beat(3'd3, pcab_pkg::SZ_WORD, 1'b1, 32'hffff_ffff));
    enqueue(cpu_beat(3'd6, pcab_pkg::SZ_DWORD, 1'b0, 32'h0));
    enqueue(cpu_beat(3'd5, pcab_pkg::SZ_BAD, 1'b1, 32'hffff_ffff));
    enqueue(cpu_beat(3'd0, pcab_pkg::SZ_BAD, 1'b0, 32'h0));
    // absent target: bus mismatch
    enqueue(cpu_beat(3'd4, pcab_pkg::SZ_DWORD, 1'b0, 32'h0));
    enqueue(cpu_beat(3'd5, pcab_pkg::SZ_BYTE, 1'b0, 32'h0));
    enqueue(cpu_beat(3'd6, pcab_pkg::SZ_WORD, 1'b0, 32'h0));
    enqueue(cpu_beat(3'd4, pcab_pkg::SZ_BYTE, 1'b1, 32'h1234_5678));
    // point at bus 0x5a slot 31, which is present
    enqueue(cpu_beat(3'd0, pcab_pkg::SZ_DWORD, 1'b1, {8'h80, 8'h5a, 5'd31, 3'd0, 8'h3c}));
    enqueue(cpu_beat(3'd6, pcab_pkg::SZ_WORD, 1'b0, 32'h0));
    enqueue(resp_beat(32'hdead_beef));
    // aligned writes of every size
    enqueue(cpu_beat(3'd4, pcab_pkg::SZ_DWORD, 1'b1, 32'hffff_ffff));
    enqueue(cpu_beat(3'd4, pcab_pkg::SZ_WORD, 1'b1, 32'h1234_abcd));
    enqueue(cpu_beat(3'd4, pcab_pkg::SZ_BYTE, 1'b1, 32'h0000_00a5));
    // byte read-modify-write at the top lane, then a stray response
    enqueue(cpu_beat(3'd7, pcab_pkg::SZ_BYTE, 1'b1, 32'hffff_ff5c));
    enqueue(resp_beat(32'h0000_0000));
    enqueue(resp_beat(32'hffff_ffff));
    // a second read replaces the pending one; sender waits for it first
    enqueue(cpu_beat(3'd5, pcab_pkg::SZ_WORD, 1'b0, 32'h0));
    a = cpu_beat(3'd7, pcab_pkg::SZ_BYTE, 1'b0, 32'h0);
    a.sync = 1'b1;
    enqueue(a);
    enqueue(resp_beat(32'h89ab_cdef));
    // read-modify-write while the slot moves to 0: write-back uses the new address
    enqueue(cpu_beat(3'd5, pcab_pkg::SZ_WORD, 1'b1, 32'h5555_abcd));
    enqueue(cpu_beat(3'd1, pcab_pkg::SZ_BYTE, 1'b1, 32'h0000_0000));
    enqueue(resp_beat(32'hffff_ffff));
  endtask

  // Mostly well-formed address-then-data sequences, with noise mixed in.
  task automatic queue_random_traffic(input int count);
    access_t     a;
    int          pick;
    int          added;
    logic [31:0] ad;
    logic [2:0]  off;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        ad = $urandom();
        if ($urandom_range(0, 4) != 0) ad[23:16] = m_bus;
        a = cpu_beat(3'd0, pcab_pkg::SZ_DWORD, 1'b1, ad);
      end else if (pick < 25) begin
        off = 3'($urandom_range(0, 3));
        a = cpu_beat(off, legal_size(off[1:0]), 1'($urandom_range(0, 1)), $urandom());
      end else if (pick < 62) begin
        off = 3'($urandom_range(4, 7));
        a = cpu_beat(off, legal_size(off[1:0]), 1'($urandom_range(0, 1)), $urandom());
        if ($urandom_range(0, 9) < 7) begin
          a.sync = ($urandom_range(0, 59) == 0);
          enqueue(a);
          added++;
          a = resp_beat($urandom());
        end
      end else if (pick < 80) begin
        a = resp_beat($urandom());
      end else begin
        a = cpu_beat(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), $urandom());
        a.func = 1'($urandom_range(0, 1));
      end
      a.sync = ($urandom_range(0, 59) == 0);
      enqueue(a);
      added++;
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = pcab_pkg::CFG_HOST_BUS;
    cfg_wdata        = 32'h0;
    in_push          = 1'b0;
    in_func          = 1'b0;
    in_port_offset   = 3'd0;
    in_size_code     = pcab_pkg::SZ_BYTE;
    in_is_write      = 1'b0;
    in_write_data    = 32'h0;
    in_response_data = 32'h0;
    out_pop          = 1'b0;
    m_bus            = 8'h00;
    m_slots          = 32'h0;
    m_addr           = 32'h0;
    m_pend           = pcab_pkg::PEND_NONE;
    m_pend_lane      = 2'd0;
    m_pend_size      = pcab_pkg::SZ_BYTE;
    m_pend_wdata     = 16'h0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    set_bridge(8'h5a, 32'h8000_0001);
    queue_directed();
    settle();

    // Sweep settings: no slots, all slots, and random slot masks on bus 0xff and on random buses.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       set_bridge(8'h00, 32'h0000_0000);
        1:       set_bridge(8'hff, 32'hffff_ffff);
        3:       set_bridge(8'h00, 32'hffff_ffff);
        4:       set_bridge(8'hff, $urandom());
        default: set_bridge(8'($urandom_range(0, 255)), $urandom());
      endcase
      queue_random_traffic(115);
      settle();
    end

    $display("Checked %0d result beats from %0d accepted accesses over %0d bridge settings",
             n_beats, n_accepted, n_settings);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/pcab_pkg.sv
hw/rtl/pcab_fifo.sv
hw/rtl/pcab_front.sv
hw/rtl/pcab_back.sv
hw/rtl/pci_config_access_bridge_unit.sv
tb/sv/tb_pci_config_access_bridge_unit.sv
